// ----- hw/rtl/tposg_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-pulse one-saw sound generator package
// Beat types, channel control struct and register map constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tposg_pkg;

    localparam logic [15:0] ADDR_PULSE_ONE = 16'h9000;
    localparam logic [15:0] ADDR_PULSE_TWO = 16'hA000;
    localparam logic [15:0] ADDR_SAW       = 16'hB000;
    localparam logic [15:0] ADDR_BASE_MASK = 16'hFFF0;

    localparam logic [1:0] REG_CTRL      = 2'd0;
    localparam logic [1:0] REG_PERIOD_LO = 2'd1;
    localparam logic [1:0] REG_PERIOD_HI = 2'd2;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic [2:0] SAW_LAST_PHASE = 3'd6;
    localparam logic [2:0] MASK_RESET     = 3'd7;
    localparam logic [5:0] MIX_MAX        = 6'd61;

    typedef struct packed {
        logic        req_type;
        logic [15:0] reg_addr;
        logic [7:0]  reg_data;
        logic [11:0] cycle_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pulse_one_level;
        logic [3:0] pulse_two_level;
        logic [4:0] saw_level;
        logic [5:0] mixed_level;
    } t_out_item;

    typedef struct packed {
        logic       wr;
        logic [1:0] reg_sel;
        logic       adv;
    } t_chan_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/tposg_pulse.sv -----
// ----------------------------------------------------------------------------
// Pulse channel
// Register decode, countdown timer and 16-step duty sequencer of one pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module tposg_pulse import tposg_pkg::*; #(
    parameter int CD_W = 15
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_chan_ctl              i_ctl,
    input  wire logic [7:0]             i_data,
    input  wire logic signed [CD_W-1:0] i_cyc,
    output logic [3:0]                  o_level_next
);

    logic signed [CD_W-1:0] r_cd, n_cd;
    logic [11:0]            r_period, n_period;
    logic [3:0]             r_volume, n_volume;
    logic [2:0]             r_duty, n_duty;
    logic                   r_enable, n_enable;
    logic                   r_force, n_force;
    logic [3:0]             r_phase, n_phase;
    logic [3:0]             r_out, n_out;
    logic signed [CD_W-1:0] w_t;
    logic                   w_step;

    always_comb begin
        n_cd     = r_cd;
        n_period = r_period;
        n_volume = r_volume;
        n_duty   = r_duty;
        n_enable = r_enable;
        n_force  = r_force;
        n_phase  = r_phase;
        n_out    = r_out;
        w_t      = r_cd;
        w_step   = 1'b0;
        if (i_ctl.wr) begin
            case (i_ctl.reg_sel)
                REG_CTRL: begin
                    n_volume = i_data[3:0];
                    n_duty   = i_data[6:4];
                    n_force  = i_data[7];
                    if (i_data[7]) begin
                        n_out = i_data[3:0];
                    end
                end
                REG_PERIOD_LO: begin
                    n_period = {r_period[11:8], i_data};
                end
                REG_PERIOD_HI: begin
                    n_enable = i_data[7];
                    n_period = {i_data[3:0], r_period[7:0]};
                    if (!i_data[7]) begin
                        n_out = 4'd0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.adv) begin
            if (r_cd > 0) begin
                w_t    = r_cd - i_cyc;
                w_step = (w_t <= 0);
            end else begin
                w_step = 1'b1;
            end
            n_cd = w_t;
            if (w_step) begin
                n_cd    = w_t + signed'(CD_W'({1'b0, r_period} + 13'd1));
                n_out   = (r_enable && (r_force || r_phase <= {1'b0, r_duty})) ?
                          r_volume : 4'd0;
                n_phase = r_phase + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd     <= '0;
            r_period <= '0;
            r_volume <= '0;
            r_duty   <= '0;
            r_enable <= 1'b0;
            r_force  <= 1'b0;
            r_phase  <= '0;
            r_out    <= '0;
        end else begin
            r_cd     <= n_cd;
            r_period <= n_period;
            r_volume <= n_volume;
            r_duty   <= n_duty;
            r_enable <= n_enable;
            r_force  <= n_force;
            r_phase  <= n_phase;
            r_out    <= n_out;
        end
    end

    assign o_level_next = n_out;

endmodule

`default_nettype wire

// ----- hw/rtl/tposg_saw.sv -----
// ----------------------------------------------------------------------------
// Sawtooth channel
// Register decode, countdown timer and six-step rate accumulator of the saw.
// ----------------------------------------------------------------------------
`default_nettype none

module tposg_saw import tposg_pkg::*; #(
    parameter int CD_W = 15
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_chan_ctl              i_ctl,
    input  wire logic [7:0]             i_data,
    input  wire logic signed [CD_W-1:0] i_cyc,
    output logic [4:0]                  o_level_next
);

    logic signed [CD_W-1:0] r_cd, n_cd;
    logic [11:0]            r_period, n_period;
    logic [5:0]             r_rate, n_rate;
    logic                   r_enable, n_enable;
    logic [2:0]             r_phase, n_phase;
    logic [7:0]             r_accum, n_accum;
    logic [4:0]             r_out, n_out;
    logic signed [CD_W-1:0] w_t;
    logic                   w_step;
    logic [7:0]             w_sum;

    always_comb begin
        n_cd     = r_cd;
        n_period = r_period;
        n_rate   = r_rate;
        n_enable = r_enable;
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_out    = r_out;
        w_t      = r_cd;
        w_step   = 1'b0;
        w_sum    = r_accum + {2'b00, r_rate};
        if (i_ctl.wr) begin
            case (i_ctl.reg_sel)
                REG_CTRL: begin
                    n_rate = i_data[5:0];
                end
                REG_PERIOD_LO: begin
                    n_period = {r_period[11:8], i_data};
                end
                REG_PERIOD_HI: begin
                    n_enable = i_data[7];
                    n_period = {i_data[3:0], r_period[7:0]};
                    if (!i_data[7]) begin
                        n_out = 5'd0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.adv) begin
            if (r_cd > 0) begin
                w_t    = r_cd - i_cyc;
                w_step = (w_t <= 0);
            end else begin
                w_step = 1'b1;
            end
            n_cd = w_t;
            if (w_step) begin
                n_cd = w_t + signed'(CD_W'({({1'b0, r_period} + 13'd1), 1'b0}));
                if (r_phase >= SAW_LAST_PHASE) begin
                    n_phase = 3'd0;
                    n_accum = 8'd0;
                    n_out   = 5'd0;
                end else begin
                    n_phase = r_phase + 3'd1;
                    if (!r_enable) begin
                        n_out = 5'd0;
                    end else begin
                        n_accum = w_sum;
                        n_out   = w_sum[7:3];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd     <= '0;
            r_period <= '0;
            r_rate   <= '0;
            r_enable <= 1'b0;
            r_phase  <= '0;
            r_accum  <= '0;
            r_out    <= '0;
        end else begin
            r_cd     <= n_cd;
            r_period <= n_period;
            r_rate   <= n_rate;
            r_enable <= n_enable;
            r_phase  <= n_phase;
            r_accum  <= n_accum;
            r_out    <= n_out;
        end
    end

    assign o_level_next = n_out;

endmodule

`default_nettype wire

// ----- hw/rtl/two_pulse_one_saw_sound_generator.sv -----
// ----------------------------------------------------------------------------
// Two-pulse one-saw sound generator
// Takes register-write and time-advance beats and returns the three channel
// levels and their masked sum for every beat.
//
//   Channel   Direction  Signals                         Beat
//   in        input      i_in_valid, o_in_stall, i_in    t_in_item
//   out       output     o_out_valid, i_out_stall, o_out t_out_item
//   cfg       input      i_cfg_we, i_cfg_wdata           channel enable mask
//
// One beat is accepted per cycle while the input is not stalled; its result
// is formed from the input register and held in the result register.
// The rate is set by the input register feeding one pass of channel logic
// into the result register.
// A stall on the output holds the result; the input stalls while the input
// register holds a beat and the result register holds a stalled result.
// Synchronous active-low reset clears all channel state and sets the mask.
// ----------------------------------------------------------------------------
`default_nettype none

module two_pulse_one_saw_sound_generator import tposg_pkg::*; #(
    parameter int CYCLE_BITS = 12
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out,
    input  wire logic      i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata
);

    localparam int CD_W = (CYCLE_BITS + 2 > 15) ? CYCLE_BITS + 2 : 15;

    logic                   r_in_valid;
    t_in_item               r_in;
    logic                   r_out_valid;
    t_out_item              r_out;
    logic [2:0]             r_mask;
    logic                   w_adv_ok;
    logic                   w_fire;
    logic signed [CD_W-1:0] w_cyc;
    logic [15:0]            w_base;
    logic                   w_reg_ok;
    t_chan_ctl              w_ctl_p1;
    t_chan_ctl              w_ctl_p2;
    t_chan_ctl              w_ctl_saw;
    logic [3:0]             w_p1_level;
    logic [3:0]             w_p2_level;
    logic [4:0]             w_saw_level;
    logic [5:0]             w_mix;

    assign w_adv_ok   = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_adv_ok;
    assign o_in_stall = r_in_valid && !w_adv_ok;

    always_comb begin
        for (int k = 0; k < CD_W; k++) begin
            w_cyc[k] = (k < CYCLE_BITS && k < 12) ? r_in.cycle_count[k % 12] : 1'b0;
        end
    end

    assign w_base   = r_in.reg_addr & ADDR_BASE_MASK;
    assign w_reg_ok = (r_in.reg_addr[3:0] <= 4'd2);

    always_comb begin
        w_ctl_p1.reg_sel  = r_in.reg_addr[1:0];
        w_ctl_p2.reg_sel  = r_in.reg_addr[1:0];
        w_ctl_saw.reg_sel = r_in.reg_addr[1:0];
        w_ctl_p1.adv      = w_fire && (r_in.req_type == REQ_ADVANCE);
        w_ctl_p2.adv      = w_ctl_p1.adv;
        w_ctl_saw.adv     = w_ctl_p1.adv;
        w_ctl_p1.wr       = w_fire && (r_in.req_type == REQ_WRITE) && w_reg_ok &&
                            (w_base == ADDR_PULSE_ONE);
        w_ctl_p2.wr       = w_fire && (r_in.req_type == REQ_WRITE) && w_reg_ok &&
                            (w_base == ADDR_PULSE_TWO);
        w_ctl_saw.wr      = w_fire && (r_in.req_type == REQ_WRITE) && w_reg_ok &&
                            (w_base == ADDR_SAW);
    end

    tposg_pulse #(
        .CD_W (CD_W)
    ) u_pulse_one (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_p1),
        .i_data       (r_in.reg_data),
        .i_cyc        (w_cyc),
        .o_level_next (w_p1_level)
    );

    tposg_pulse #(
        .CD_W (CD_W)
    ) u_pulse_two (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_p2),
        .i_data       (r_in.reg_data),
        .i_cyc        (w_cyc),
        .o_level_next (w_p2_level)
    );

    tposg_saw #(
        .CD_W (CD_W)
    ) u_saw (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_saw),
        .i_data       (r_in.reg_data),
        .i_cyc        (w_cyc),
        .o_level_next (w_saw_level)
    );

    assign w_mix = (r_mask[0] ? {2'b00, w_p1_level} : 6'd0) +
                   (r_mask[1] ? {2'b00, w_p2_level} : 6'd0) +
                   (r_mask[2] ? {1'b0, w_saw_level} : 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= MASK_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv_ok) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_out.pulse_one_level <= w_p1_level;
            r_out.pulse_two_level <= w_p2_level;
            r_out.saw_level       <= w_saw_level;
            r_out.mixed_level     <= w_mix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled without a full pipeline");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed beat did not produce a result");

    a_held_input_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in))
        else $error("held input register changed");

    a_mix_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.mixed_level <= MIX_MAX)
        else $error("mixed level out of range");

endmodule

`default_nettype wire
